FILE: rtl/core/trpm_pkg.sv
// ----------------------------------------------------------------------------
// trpm_pkg
// shared types and constants for the text record pattern matcher
// ----------------------------------------------------------------------------
package trpm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int CHAR_W      = 8;
  localparam int SKIP_W      = 6;
  localparam int S_DATA_W    = 8;
  localparam int S_USER_W    = 2;
  localparam int M_DATA_W    = 8;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic {
    REG_MATCH_MODE = 1'b0,
    REG_MAX_SKIPS  = 1'b1
  } reg_idx_t;

  // control broadcast to every cell for the request in flight
  typedef struct packed {
    logic              clear_pat;
    logic              append;
    logic              text;
    logic              rec_clear;
    logic [CHAR_W-1:0] char_code;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/text_record_pattern_matcher.sv
// ----------------------------------------------------------------------------
// text_record_pattern_matcher
// matches streamed text records against a stored pattern, contiguous
// substring (shift-and) or subsequence with a skip limit
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    s_tuser: op[1:0]; s_tdata: char_code[7:0]; s_tlast
//  m_*       out  m_tvalid / m_tready    m_tdata: matched[0]
//  cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one request per cycle while s_tready is high; all pattern positions
//  update in the same cycle in a row of PATTERN_MAX cells; the result is
//  registered in the output register or its skid entry for the request that ends a record
//  s_tready drops only when the output register and its skid entry are full
//  rst is synchronous; the pattern characters themselves are not cleared,
//  only their fill bits
// ----------------------------------------------------------------------------
module text_record_pattern_matcher
  import trpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_USER_W-1:0] s_tuser,   // op[1:0]
  input  logic [S_DATA_W-1:0] s_tdata,   // char_code[7:0]
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // matched[0], zero pad
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [SKIP_W-1:0]   cfg_data
);

  logic                   match_mode;
  logic [SKIP_W-1:0]      max_skips;
  logic [SKIP_W-1:0]      skip_count;
  logic                   gave_up;
  logic                   found;

  logic                   accept;
  op_t                    op;
  cell_ctrl_t             ctrl;

  logic [PATTERN_MAX-1:0] valid;
  logic [PATTERN_MAX-1:0] match;
  logic [PATTERN_MAX-1:0] ptr;
  logic [PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0] hit_last;
  logic [PATTERN_MAX-1:0] ptr_live_new;
  logic [PATTERN_MAX-1:0] next_valid;

  logic                   active;
  logic                   ptr_eq;
  logic                   advance;
  logic                   res_valid;
  logic                   res_bit;

  assign accept = s_tvalid & s_tready;
  assign op     = op_t'(s_tuser);

  always_comb begin
    ctrl           = '0;
    ctrl.char_code = s_tdata[CHAR_W-1:0];
    if (accept) begin
      case (op)
        OP_CLEAR: begin
          ctrl.clear_pat = 1'b1;
          ctrl.rec_clear = 1'b1;
        end
        OP_APPEND: begin
          ctrl.append    = 1'b1;
          ctrl.rec_clear = 1'b1;
        end
        OP_TEXT: begin
          ctrl.text      = 1'b1;
          ctrl.rec_clear = s_tlast;
        end
        default: begin
        end
      endcase
    end
  end

  // pointer in a filled cell (progress below pattern length) and record not given up
  assign active  = (|(ptr & valid)) & ~gave_up;
  assign ptr_eq  = |(ptr & eq);
  assign advance = ctrl.text & active & ptr_eq;

  assign next_valid = {1'b0, valid[PATTERN_MAX-1:1]};

  genvar g;
  generate
    for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
      trpm_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .head         (g == 0),
        .advance      (advance),
        .prev_valid   ((g == 0) ? 1'b1 : valid[(g == 0) ? 0 : g-1]),
        .prev_match   ((g == 0) ? 1'b1 : match[(g == 0) ? 0 : g-1]),
        .prev_ptr     ((g == 0) ? 1'b0 : ptr[(g == 0) ? 0 : g-1]),
        .next_valid   (next_valid[g]),
        .valid        (valid[g]),
        .match        (match[g]),
        .ptr          (ptr[g]),
        .eq           (eq[g]),
        .hit_last     (hit_last[g]),
        .ptr_live_new (ptr_live_new[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      skip_count <= '0;
      gave_up    <= 1'b0;
    end else if (ctrl.rec_clear) begin
      found      <= 1'b0;
      skip_count <= '0;
      gave_up    <= 1'b0;
    end else if (ctrl.text) begin
      if (|hit_last) begin
        found <= 1'b1;
      end
      if (active && !ptr_eq) begin
        if (skip_count >= max_skips) begin
          gave_up <= 1'b1;
        end else begin
          skip_count <= skip_count + 1'b1;
        end
      end
    end
  end

  // empty pattern never matches; subsequence done once pointer leaves the pattern
  assign res_valid = ctrl.text & s_tlast;
  assign res_bit   = valid[0] & (match_mode ? ~(|ptr_live_new) : (found | (|hit_last)));

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode <= 1'b0;
      max_skips  <= SKIP_W'(1);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MATCH_MODE: match_mode <= cfg_data[0];
        REG_MAX_SKIPS:  max_skips  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  trpm_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_bit   (res_bit),
    .in_ready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: rtl/core/trpm_cell.sv
// ----------------------------------------------------------------------------
// trpm_cell
// one pattern position: stored character, plus fill bit, shift-and bit and
// subsequence pointer bit, the three bits each handed on to the next cell
// ----------------------------------------------------------------------------
module trpm_cell
  import trpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       head,
  input  logic       advance,
  input  logic       prev_valid,
  input  logic       prev_match,
  input  logic       prev_ptr,
  input  logic       next_valid,
  output logic       valid,
  output logic       match,
  output logic       ptr,
  output logic       eq,
  output logic       hit_last,
  output logic       ptr_live_new
);

  logic [CHAR_W-1:0] pat;
  logic              match_new;
  logic              ptr_new;

  assign eq           = valid & (pat == ctrl.char_code);
  assign match_new    = prev_match & eq;
  assign ptr_new      = advance ? prev_ptr : ptr;
  // full pattern seen when the last filled cell matches
  assign hit_last     = match_new & valid & ~next_valid;
  assign ptr_live_new = ptr_new & valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear_pat) begin
      valid <= 1'b0;
    end else if (ctrl.append && prev_valid && !valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && prev_valid && !valid) begin
      pat <= ctrl.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
      ptr   <= head;
    end else if (ctrl.rec_clear) begin
      match <= 1'b0;
      ptr   <= head;
    end else if (ctrl.text) begin
      match <= match_new;
      ptr   <= ptr_new;
    end
  end

endmodule

FILE: rtl/core/trpm_out_reg.sv
// ----------------------------------------------------------------------------
// trpm_out_reg
// output register with one skid entry for match results
// ----------------------------------------------------------------------------
module trpm_out_reg
  import trpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  logic                res_bit,
  output logic                in_ready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata
);

  logic out_bit;
  logic sk_valid;
  logic sk_bit;

  assign in_ready = ~sk_valid;
  assign m_tdata  = {{(M_DATA_W-1){1'b0}}, out_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sk_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= sk_valid | res_valid;
      sk_valid <= 1'b0;
    end else if (res_valid) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_bit <= sk_valid ? sk_bit : res_bit;
    end else if (res_valid) begin
      sk_bit <= res_bit;
    end
  end

endmodule
